FILE: src/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Operation and status codes, port field layout and the cell command type.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int WORD_WIDTH_DEF = 32;

   // port field widths
   localparam int OP_W   = 2;
   localparam int DATA_W = 32;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   // result tdata layout, lowest bit up
   localparam int RSP_FRONT_LSB = 0;
   localparam int RSP_BACK_LSB  = RSP_FRONT_LSB + DATA_W;
   localparam int RSP_OCC_LSB   = RSP_BACK_LSB + DATA_W;
   localparam int RSP_EMPTY_BIT = RSP_OCC_LSB + OCC_W;
   localparam int RSP_FULL_BIT  = RSP_EMPTY_BIT + 1;
   localparam int RSP_STAT_LSB  = RSP_FULL_BIT + 1;
   localparam int RSP_USED_W    = RSP_STAT_LSB + STAT_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // per-chain command, broadcast to every cell
   typedef struct packed {
      logic shift_up;    // cell i takes cell i-1, cell 0 takes the new word
      logic shift_down;  // cell i takes cell i+1
      logic write_at;    // the cell whose index equals the count takes the new word
   } cell_cmd_type;

endpackage
`default_nettype wire

FILE: src/dq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of a queue chain
// Holds one word; loads from a neighbor or the new word per the chain command.
// ----------------------------------------------------------------------------
module dq_cell import dq_pkg::*; #(
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire cell_cmd_type          cmd,
   input  wire logic [CNT_W-1:0]      count,
   input  wire logic [WORD_WIDTH-1:0] new_word,
   input  wire logic [WORD_WIDTH-1:0] up_word,     // lower neighbor (or new word)
   input  wire logic [WORD_WIDTH-1:0] down_word,   // upper neighbor
   output logic      [WORD_WIDTH-1:0] word
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [WORD_WIDTH-1:0] data_ff;
   logic [WORD_WIDTH-1:0] data_in;

   always_comb begin
      priority if (cmd.shift_up) begin
         data_in = up_word;
      end else if (cmd.shift_down) begin
         data_in = down_word;
      end else if (cmd.write_at && (count == MY_INDEX)) begin
         data_in = new_word;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word = data_ff;

endmodule
`default_nettype wire

FILE: src/dq_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_chain: row of cells with one end fixed
// Cell 0 always holds the word at this chain's end of the queue.
// ----------------------------------------------------------------------------
module dq_chain import dq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF,
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire cell_cmd_type          cmd,
   input  wire logic [CNT_W-1:0]      count,
   input  wire logic [WORD_WIDTH-1:0] new_word,
   output logic      [WORD_WIDTH-1:0] end_word
);

   logic [WORD_WIDTH-1:0] cell_word [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] up_word;
      logic [WORD_WIDTH-1:0] down_word;

      if (i == 0) begin : g_first
         assign up_word = new_word;
      end else begin : g_mid_up
         assign up_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign down_word = cell_word[i];
      end else begin : g_mid_down
         assign down_word = cell_word[i+1];
      end

      dq_cell #(
         .CNT_W      (CNT_W),
         .INDEX      (i),
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count),
         .new_word  (new_word),
         .up_word   (up_word),
         .down_word (down_word),
         .word      (cell_word[i])
      );
   end

   assign end_word = cell_word[0];

endmodule
`default_nettype wire

FILE: src/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque built from two shifting cell chains
// Push/pop at either end, one result item per request item.
// ----------------------------------------------------------------------------
// Usage
//  - Request channel req_*: tuser carries the operation (push front, push
//    back, pop front, pop back), tdata the word to push.
//  - Result channel rsp_*: one item per request with the front and back words
//    after the operation, occupancy, empty/full flags and a status code
//    (ok, pop from empty, push into full). A rejected operation changes
//    nothing.
//  - Latency: the result is valid the cycle after the request is accepted.
//  - Throughput: one item per cycle unless stalled. Each operation is a
//    single broadcast command into two rows of DEPTH cells: one row keeps
//    the front word in its cell 0, the other keeps the back word in its
//    cell 0 (reverse order), so both ends are read at fixed places.
//  - Stall: the result register holds while rsp_tready is low; req_tready
//    is high whenever that register is empty or being drained this cycle.
//  - Reset: synchronous; the queue comes up empty, no result pending. The
//    cells are not cleared: only cells below the count are ever shown.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [DATA_W-1:0]      req_tdata,   // [31:0] data_in
   input  wire logic [OP_W-1:0]        req_tuser,   // [1:0] op
   // result
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata    // [31:0] front_word,
                                                    // [63:32] back_word,
                                                    // [68:64] occupancy,
                                                    // [69] is_empty,
                                                    // [70] is_full,
                                                    // [72:71] status, rest zero
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   status_type       status_ff;
   status_type       status_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   logic                  accept;
   op_type                op;
   logic [WORD_WIDTH-1:0] new_word;
   cell_cmd_type          front_cmd;
   cell_cmd_type          back_cmd;
   logic [WORD_WIDTH-1:0] front_raw;
   logic [WORD_WIDTH-1:0] back_raw;
   logic [DATA_W-1:0]     front_out;
   logic [DATA_W-1:0]     back_out;
   logic                  is_empty;
   logic                  is_full;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);

   // input word to storage width
   if (WORD_WIDTH > DATA_W) begin : g_in_ext
      assign new_word = {{(WORD_WIDTH - DATA_W){1'b0}}, req_tdata};
   end else begin : g_in_cut
      assign new_word = req_tdata[WORD_WIDTH-1:0];
   end

   // ---------------------------------------------------------------------
   // decode: commands to both chains, next count and status
   // front chain: cell 0 = front; back chain: cell 0 = back
   // ---------------------------------------------------------------------
   always_comb begin
      front_cmd = '0;
      back_cmd  = '0;
      count_in  = count_ff;
      status_in = status_ff;
      if (accept) begin
         status_in = ST_OK;
         unique case (op)
            OP_PUSH_FRONT: begin
               if (count_ff == CNT_FULL) begin
                  status_in = ST_FULL;
               end else begin
                  front_cmd.shift_up = 1'b1;
                  back_cmd.write_at  = 1'b1;   // new far end of the back chain
                  count_in           = count_ff + CNT_ONE;
               end
            end
            OP_PUSH_BACK: begin
               if (count_ff == CNT_FULL) begin
                  status_in = ST_FULL;
               end else begin
                  front_cmd.write_at = 1'b1;
                  back_cmd.shift_up  = 1'b1;
                  count_in           = count_ff + CNT_ONE;
               end
            end
            OP_POP_FRONT: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  front_cmd.shift_down = 1'b1;  // back chain just forgets its tail
                  count_in             = count_ff - CNT_ONE;
               end
            end
            OP_POP_BACK: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  back_cmd.shift_down = 1'b1;
                  count_in            = count_ff - CNT_ONE;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   // result register: filled on accept, drained on rsp_tready
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // the two cell chains
   // ---------------------------------------------------------------------
   dq_chain #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W)
   ) u_front_chain (
      .clock    (clock),
      .cmd      (front_cmd),
      .count    (count_ff),
      .new_word (new_word),
      .end_word (front_raw)
   );

   dq_chain #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W)
   ) u_back_chain (
      .clock    (clock),
      .cmd      (back_cmd),
      .count    (count_ff),
      .new_word (new_word),
      .end_word (back_raw)
   );

   // ---------------------------------------------------------------------
   // result payload straight from state; it only moves when the item is taken
   // ---------------------------------------------------------------------
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_FULL);

   if (WORD_WIDTH >= DATA_W) begin : g_out_cut
      assign front_out = is_empty ? '0 : front_raw[DATA_W-1:0];
      assign back_out  = is_empty ? '0 : back_raw[DATA_W-1:0];
   end else begin : g_out_ext
      assign front_out = is_empty ? '0 : {{(DATA_W - WORD_WIDTH){1'b0}}, front_raw};
      assign back_out  = is_empty ? '0 : {{(DATA_W - WORD_WIDTH){1'b0}}, back_raw};
   end

   // occupancy field keeps the low bits of the count
   logic [OCC_W-1:0] occupancy;
   if (CNT_W >= OCC_W) begin : g_occ_cut
      assign occupancy = count_ff[OCC_W-1:0];
   end else begin : g_occ_ext
      assign occupancy = {{(OCC_W - CNT_W){1'b0}}, count_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_USED_W){1'b0}},
                        status_ff, is_full, is_empty, occupancy, back_out, front_out};

endmodule
`default_nettype wire

FILE: src/dq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_checker: port-level checks of the double-ended queue
// Result flags and status must agree with each other over time.
// ----------------------------------------------------------------------------
module dq_checker import dq_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic             empty;
   logic             full;
   logic [STAT_W-1:0] status;

   assign empty  = rsp_tdata[RSP_EMPTY_BIT];
   assign full   = rsp_tdata[RSP_FULL_BIT];
   assign status = rsp_tdata[RSP_STAT_LSB +: STAT_W];

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // every accepted request yields a result next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no result after accepted request");

   // an empty queue shows zero words and zero occupancy
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && empty |-> !full
         && rsp_tdata[RSP_FRONT_LSB +: DATA_W] == '0
         && rsp_tdata[RSP_BACK_LSB +: DATA_W] == '0
         && rsp_tdata[RSP_OCC_LSB +: OCC_W] == '0)
      else $error("empty result carries data");

   // rejection codes only with the matching flag
   a_status_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (status != ST_EMPTY || empty) && (status != ST_FULL || full)
         && (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
      else $error("status disagrees with flags");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

FILE: dv/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test: self-checking bench for the double-ended queue
// A directed table walks the empty and full edges and the extreme words.
// After it come about 500 random push/pop items, with insert-heavy and
// remove-heavy stretches so the occupancy sweeps between empty and full.
// Every result is checked field by field against a typed row or a deque model.
// The sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
   import dq_pkg::*;

   localparam int DEPTH        = DEPTH_DEF;
   localparam int SLOT_W       = $clog2(DEPTH);
   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_CYCLES  = 48;      // long receiver hold-off
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;       // result lands the cycle after accept

   // What the result channel shows after one operation.
   typedef struct packed {
      logic [DATA_W-1:0] front;
      logic [DATA_W-1:0] back;
      logic [OCC_W-1:0]  occ;
      logic              empty;
      logic              full;
      status_type        status;
   } deque_view_type;

   // One row of the directed table. Rows with known_view set carry the
   // expected result typed in; the rest are predicted.
   typedef struct {
      op_type            op;
      logic [DATA_W-1:0] word;
      bit                known_view;
      deque_view_type    view;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // model of the queue contents
   logic [DATA_W-1:0] ring_words [DEPTH];
   logic [SLOT_W-1:0] front_slot = '0;
   logic [OCC_W-1:0]  fill       = '0;

   deque_view_type pending_views [$];   // results still owed by the block

   // typed expectation travelling with the item on the request bus
   bit             cur_known = 1'b0;
   deque_view_type cur_view  = '0;

   logic hold_off_req = 1'b0;
   int   fail_count   = 0;
   int   cycle_count  = 0;

   double_ended_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Directed table: empty-queue errors, extreme words at both ends, back
   // to empty, fill to full, inserts into a full queue, then one pop back.
   stim_row_type directed_rows [0:24] = '{
      '{OP_POP_FRONT,  32'h0000_0000, 1'b1,
        '{32'h0, 32'h0, 5'd0, 1'b1, 1'b0, ST_EMPTY}},
      '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1,
        '{32'h0, 32'h0, 5'd0, 1'b1, 1'b0, ST_EMPTY}},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, 1'b0, ST_OK}},
      '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1,
        '{32'h0, 32'hFFFF_FFFF, 5'd2, 1'b0, 1'b0, ST_OK}},
      '{OP_POP_BACK,   32'h1234_5678, 1'b1,
        '{32'h0, 32'h0, 5'd1, 1'b0, 1'b0, ST_OK}},
      '{OP_POP_FRONT,  32'h0000_0000, 1'b1,
        '{32'h0, 32'h0, 5'd0, 1'b1, 1'b0, ST_OK}},
      '{OP_PUSH_FRONT, 32'h8000_0001, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h7FFF_FFFE, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h5A5A_5A5A, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h8000_0000, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hFFFF_0000, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h0000_FFFF, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h3333_3333, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hCCCC_CCCC, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h0000_0010, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h0000_0000, 1'b0, '0},    // sixteenth word: full
      '{OP_PUSH_FRONT, 32'h1111_1111, 1'b0, '0},    // rejected, queue full
      '{OP_PUSH_BACK,  32'h2222_2222, 1'b0, '0},    // rejected, queue full
      '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0}
   };

   // Applies one operation to the queue model and returns the view after it.
   function automatic deque_view_type deque_apply(op_type op, logic [DATA_W-1:0] word);
      deque_view_type v;
      v        = '0;
      v.status = ST_OK;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
         if (fill == OCC_W'(DEPTH)) begin
            v.status = ST_FULL;           // word dropped
         end else if (op == OP_PUSH_FRONT) begin
            front_slot             = front_slot - SLOT_W'(1);
            ring_words[front_slot] = word;
            fill                   = fill + OCC_W'(1);
         end else begin
            ring_words[SLOT_W'(OCC_W'(front_slot) + fill)] = word;
            fill                                           = fill + OCC_W'(1);
         end
      end else if (fill == '0) begin
         v.status = ST_EMPTY;
      end else begin
         if (op == OP_POP_FRONT) front_slot = front_slot + SLOT_W'(1);
         fill = fill - OCC_W'(1);
      end
      if (fill != '0) begin
         v.front = ring_words[front_slot];
         v.back  = ring_words[SLOT_W'(OCC_W'(front_slot) + fill - OCC_W'(1))];
      end
      v.occ   = fill;
      v.empty = (fill == '0);
      v.full  = (fill == OCC_W'(DEPTH));
      return v;
   endfunction

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Offer one item from a falling edge, hold it until taken, return at the
   // next falling edge with tvalid still high.
   task automatic send_item(op_type op, logic [DATA_W-1:0] word, bit known,
                            deque_view_type view);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      cur_known  <= known;
      cur_view   <= view;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   task automatic idle_for(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Predict at request accept, check at result accept. Request side goes
   // first so a same-cycle result would still find its expectation.
   always @(posedge clock) begin : scoreboard
      deque_view_type want;
      deque_view_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = deque_apply(op_type'(req_tuser), req_tdata);
            if (cur_known) want = cur_view;
            pending_views.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.front  = rsp_tdata[RSP_FRONT_LSB +: DATA_W];
            got.back   = rsp_tdata[RSP_BACK_LSB +: DATA_W];
            got.occ    = rsp_tdata[RSP_OCC_LSB +: OCC_W];
            got.empty  = rsp_tdata[RSP_EMPTY_BIT];
            got.full   = rsp_tdata[RSP_FULL_BIT];
            got.status = status_type'(rsp_tdata[RSP_STAT_LSB +: STAT_W]);
            if (pending_views.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, got %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_views.pop_front();
               check_field("front_word", want.front, got.front);
               check_field("back_word", want.back, got.back);
               check_field("occupancy", DATA_W'(want.occ), DATA_W'(got.occ));
               check_field("is_empty", DATA_W'(want.empty), DATA_W'(got.empty));
               check_field("is_full", DATA_W'(want.full), DATA_W'(got.full));
               check_field("status", DATA_W'(want.status), DATA_W'(got.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: stretches of always-ready, coin-flip, periodic and
   // mostly-stalled, plus one long hold-off on request.
   initial begin : receiver
      int  mode;
      int  mode_left;
      int  phase;
      bit  hold_taken;
      mode       = 0;
      mode_left  = 0;
      phase      = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            phase++;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (phase % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Sender
   initial begin : sender
      int                push_pct;
      int                burst_left;
      op_type            op;
      logic [DATA_W-1:0] word;
      push_pct   = 50;
      burst_left = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].word,
                   directed_rows[i].known_view, directed_rows[i].view);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // insert-heavy, balanced or remove-heavy stretches
         if (n % 30 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 50;
               default: push_pct = 15;
            endcase
         end
         if (n == 100) hold_off_req <= 1'b1;   // receiver holds, sender keeps going

         if (n == 250) begin
            // quiet the request side until every result is back
            req_tvalid <= 1'b0;
            do @(negedge clock); while (pending_views.size() != 0);
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
         end
         burst_left--;

         if ($urandom_range(0, 99) < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         case ($urandom_range(0, 7))
            0:       word = '0;
            1:       word = '1;
            2:       word = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: word = $urandom;
         endcase
         send_item(op, word, 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_views.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_views.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
src/dq_pkg.sv
src/dq_cell.sv
src/dq_chain.sv
src/double_ended_queue.sv
src/dq_checker.sv
dv/double_ended_queue_test.sv
